>>> hw/rtl/ljpf_pkg.sv
// Shared types, widths, operation codes and register indexes for the
// Lennard-Jones pair force accumulator. No dependencies.
package ljpf_pkg;

   // Atom storage
   localparam int ATOM_COUNT = 1024;
   localparam int ATOM_AW    = $clog2(ATOM_COUNT);

   // Field widths
   localparam int IDX_W  = 10;
   localparam int POS_W  = 22;
   localparam int CUT_W  = 28;
   localparam int COEF_W = 48;
   localparam int ACC_W  = 48;
   localparam int DIFF_W = 24;
   localparam int MAG_W  = 23;
   localparam int R2_W   = 48;
   localparam int WORD_W = 64;

   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 208;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CUT_W-1:0] CUTOFF_SQ_RESET = 28'd5308416;

   // Operation selector carried in req_tuser
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_PAIR  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_Z    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE6   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORCE12  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY6  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY12 = 3'd7;

   // Datapath operations issued by the controller
   localparam logic [3:0] DP_NOP       = 4'd0;
   localparam logic [3:0] DP_LOAD      = 4'd1;
   localparam logic [3:0] DP_CLR       = 4'd2;
   localparam logic [3:0] DP_DIFF      = 4'd3;
   localparam logic [3:0] DP_SQR       = 4'd4;
   localparam logic [3:0] DP_SUM       = 4'd5;
   localparam logic [3:0] DP_DIV_START = 4'd6;
   localparam logic [3:0] DP_DIV_STEP  = 4'd7;
   localparam logic [3:0] DP_MUL_START = 4'd8;
   localparam logic [3:0] DP_RD_I      = 4'd9;
   localparam logic [3:0] DP_WR_I      = 4'd10;
   localparam logic [3:0] DP_RD_J      = 4'd11;
   localparam logic [3:0] DP_WR_J      = 4'd12;
   localparam logic [3:0] DP_RD_A      = 4'd13;
   localparam logic [3:0] DP_RSP_LOAD  = 4'd14;

   // Product sequence through the shared multiplier
   localparam logic [3:0] MUL_INV4   = 4'd0;
   localparam logic [3:0] MUL_INV6   = 4'd1;
   localparam logic [3:0] MUL_INV8   = 4'd2;
   localparam logic [3:0] MUL_INV12  = 4'd3;
   localparam logic [3:0] MUL_INV14  = 4'd4;
   localparam logic [3:0] MUL_TF6    = 4'd5;
   localparam logic [3:0] MUL_F      = 4'd6;
   localparam logic [3:0] MUL_TE12   = 4'd7;
   localparam logic [3:0] MUL_E      = 4'd8;
   localparam logic [3:0] MUL_COMP_X = 4'd9;
   localparam logic [3:0] MUL_COMP_Y = 4'd10;
   localparam logic [3:0] MUL_COMP_Z = 4'd11;

   typedef struct packed {
      logic [1:0]       func;
      logic [IDX_W-1:0] index_i;
      logic [IDX_W-1:0] index_j;
      logic [POS_W-1:0] pos_i_x;
      logic [POS_W-1:0] pos_i_y;
      logic [POS_W-1:0] pos_i_z;
      logic [POS_W-1:0] pos_j_x;
      logic [POS_W-1:0] pos_j_y;
      logic [POS_W-1:0] pos_j_z;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] atom_index;
      logic [ACC_W-1:0] force_x;
      logic [ACC_W-1:0] force_y;
      logic [ACC_W-1:0] force_z;
      logic [ACC_W-1:0] energy_total;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] mul_idx;
   } cmd_type;

   typedef struct packed {
      logic pair_ok;
      logic clr_last;
      logic div_last;
      logic mul_done;
   } status_type;

endpackage

>>> hw/rtl/lennard_jones_pair_force_accumulator.sv
// Top level of the Lennard-Jones 12-6 pair force accumulator.
// Depends on ljpf_pkg, ljpf_ctrl and ljpf_dpath.
//
// Usage:
//   req: one beat is one operation, chosen by req_tuser: clear, pair or read.
//   rsp: a read gives one beat with the atom's force and the energy total;
//        clear and pair give none.
//   csr: writes a configuration register by index; always ready. Write it
//        only while no operation is in flight.
// Sequencing:
//   A read passes through a memory read state and a result state, which loads
//   the result register and the rsp_tvalid register, and waits there while an
//   untaken beat is held. A clear passes over the force memory, one row a cycle.
//   A pair skipped by the index or cutoff test returns to idle after the check;
//   a pair that interacts runs the bit-serial divider, 12 products through one
//   32x32 multiplier, and a read-modify-write of atom i and then of atom j on
//   the read and write ports of the force memory.
//   One operation is in flight at a time; req_tready is high between them.
// Reset: the configuration returns to its reset values and a clearing pass
//   zeroes the force memory before the first beat.
// Stall: a result beat waits in its output register while rsp_tready is low;
//   the next request is still taken, and a following read waits for it.
module lennard_jones_pair_force_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: index_i, index_j, pos_i_x, pos_i_y, pos_i_z,
   //            pos_j_x, pos_j_y, pos_j_z
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ljpf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: func
   input  logic [1:0]                          req_tuser,
   // rsp_tdata: atom_index, force_x, force_y, force_z, energy_total, zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ljpf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ljpf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ljpf_pkg::CSR_DATA_W-1:0]     csr_data
);

   ljpf_pkg::req_type    req_data;
   ljpf_pkg::rsp_type    rsp_data;
   ljpf_pkg::cmd_type    cmd;
   ljpf_pkg::status_type status;

   // Unpack the request beat.
   assign req_data.func    = req_tuser;
   assign req_data.index_i = req_tdata[9:0];
   assign req_data.index_j = req_tdata[19:10];
   assign req_data.pos_i_x = req_tdata[41:20];
   assign req_data.pos_i_y = req_tdata[63:42];
   assign req_data.pos_i_z = req_tdata[85:64];
   assign req_data.pos_j_x = req_tdata[107:86];
   assign req_data.pos_j_y = req_tdata[129:108];
   assign req_data.pos_j_z = req_tdata[151:130];

   // Pack the result beat.
   assign rsp_tdata = {6'b000000, rsp_data.energy_total, rsp_data.force_z,
                       rsp_data.force_y, rsp_data.force_x, rsp_data.atom_index};

   assign csr_ready = 1'b1;

   ljpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ljpf_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/ljpf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ljpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and read data that holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ljpf_mul.sv
// Shared 64x64 multiplier built from four partial products of one 32x32
// multiplier, with a right shift and saturation. No dependencies.
module ljpf_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   input  logic        sh16,
   input  logic        cap47,
   output logic        done,
   output logic [63:0] result
);

   localparam logic [2:0] STEP_LAST_PP = 3'd3;
   localparam logic [2:0] STEP_LAST_ACC = 3'd4;
   localparam logic [2:0] STEP_FINAL = 3'd5;
   localparam logic [63:0] CAP_47 = 64'h0000_7FFF_FFFF_FFFF;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [2:0]    step_ff, step_in;
   logic [63:0]   a_ff, b_ff;
   logic          sh16_ff, cap47_ff;
   logic [63:0]   pp_ff;
   logic [1:0]    pp_pos_ff;
   logic [127:0]  acc_ff;
   logic [63:0]   result_ff;
   logic [31:0]   a_half, b_half;
   logic [63:0]   pp_in;
   logic [127:0]  pp_shifted;
   logic          over;
   logic [63:0]   val;

   // Partial product select: a0b0, a0b1, a1b0, a1b1.
   assign a_half = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp_in  = a_half * b_half;

   always_comb begin
      unique case (pp_pos_ff)
         2'd0:    pp_shifted = {64'b0, pp_ff};
         2'd1:    pp_shifted = {32'b0, pp_ff, 32'b0};
         2'd2:    pp_shifted = {pp_ff, 64'b0};
         default: pp_shifted = '0;
      endcase
   end

   // Shift and saturation of the finished product.
   always_comb begin
      if (sh16_ff) begin
         over = |acc_ff[127:80];
         val  = acc_ff[79:16];
      end else begin
         over = |acc_ff[127:96];
         val  = acc_ff[95:32];
      end
      if (cap47_ff && (|val[63:47])) begin
         over = 1'b1;
      end
   end

   // Step sequencing.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == STEP_FINAL) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Operand capture, partial products and accumulation.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff     <= op_a;
         b_ff     <= op_b;
         sh16_ff  <= sh16;
         cap47_ff <= cap47;
         acc_ff   <= '0;
      end else if (busy_ff) begin
         if (step_ff <= STEP_LAST_PP) begin
            pp_ff     <= pp_in;
            pp_pos_ff <= {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
         end
         if ((step_ff != '0) && (step_ff <= STEP_LAST_ACC)) begin
            acc_ff <= acc_ff + pp_shifted;
         end
         if (step_ff == STEP_FINAL) begin
            result_ff <= over ? (cap47_ff ? CAP_47 : '1) : val;
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> hw/rtl/ljpf_dpath.sv
// Datapath: configuration registers, minimum image, squared distance,
// divider, power chain, force accumulator memory. Depends on ljpf_pkg,
// ljpf_ram and ljpf_mul.
module ljpf_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  ljpf_pkg::cmd_type                   cmd,
   output ljpf_pkg::status_type                status,
   input  ljpf_pkg::req_type                   req_data,
   input  logic                                csr_write,
   input  logic [ljpf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ljpf_pkg::CSR_DATA_W-1:0]     csr_data,
   output ljpf_pkg::rsp_type                   rsp_data
);

   localparam int AW = ljpf_pkg::ATOM_AW;
   localparam int AccW = ljpf_pkg::ACC_W;
   localparam int MAG_W = ljpf_pkg::MAG_W;
   localparam logic [AW-1:0] CLR_LAST = AW'(ljpf_pkg::ATOM_COUNT - 1);
   localparam logic [5:0] DIV_LAST = 6'd63;

   // Configuration registers
   logic [ljpf_pkg::POS_W-1:0]  box_x_ff, box_y_ff, box_z_ff;
   logic [ljpf_pkg::CUT_W-1:0]  cutoff_ff;
   logic [ljpf_pkg::COEF_W-1:0] cf6_ff, cf12_ff, ce6_ff, ce12_ff;

   ljpf_pkg::req_type req_ff;

   logic signed [ljpf_pkg::DIFF_W-1:0] d_x_ff, d_y_ff, d_z_ff;
   logic [ljpf_pkg::R2_W-1:0]          sq_x_ff, sq_y_ff, sq_z_ff, r2_ff;
   logic [ljpf_pkg::R2_W-1:0]          rem_ff;
   logic [63:0]                        q_ff;
   logic [5:0]                         div_cnt_ff;
   logic [63:0]                        inv4_ff, inv6_ff, inv8_ff, inv12_ff, inv14_ff;
   logic [AccW-1:0]                    tf6_ff, te12_ff, mag_f_ff;
   logic signed [AccW-1:0]             f_ff, e_ff, energy_ff;
   logic [ljpf_pkg::MAG_W-1:0]         mag_x_ff, mag_y_ff, mag_z_ff;
   logic signed [AccW-1:0]             cx_ff, cy_ff, cz_ff, ncx_ff, ncy_ff, ncz_ff;
   logic [AW-1:0]                      clr_cnt_ff;
   logic [3:0]                         mul_dest_ff;
   ljpf_pkg::rsp_type                  rsp_ff;

   logic signed [2*ljpf_pkg::DIFF_W-1:0] sq_x, sq_y, sq_z;
   logic [ljpf_pkg::R2_W:0]              trial;
   logic                                 trial_ge;
   logic                                 in_range_i, in_range_j;
   logic                                 mul_start, mul_sh16, mul_cap47, mul_done;
   logic [63:0]                          mul_a, mul_b, mul_res;
   logic [AccW-1:0]                      res48;
   logic                                 comp_neg;
   logic                                 wr_en, rd_en;
   logic [AW-1:0]                        wr_addr, rd_addr, addr_i, addr_j;
   logic [3*AccW-1:0]                    wr_data, rd_data;
   logic signed [AccW-1:0]               add_x, add_y, add_z;

   function automatic logic signed [ljpf_pkg::DIFF_W-1:0] wrap_image(
      input logic [ljpf_pkg::POS_W-1:0] pi,
      input logic [ljpf_pkg::POS_W-1:0] pj,
      input logic [ljpf_pkg::POS_W-1:0] len);
      logic signed [ljpf_pkg::DIFF_W-1:0] d;
      logic signed [ljpf_pkg::DIFF_W:0]   twod;
      logic signed [ljpf_pkg::DIFF_W:0]   l;
      logic signed [ljpf_pkg::DIFF_W-1:0] ls;
      d    = $signed({2'b00, pj}) - $signed({2'b00, pi});
      twod = {d, 1'b0};
      l    = $signed({3'b000, len});
      ls   = $signed({2'b00, len});
      if (twod > l) begin
         wrap_image = d - ls;
      end else if (twod < -l) begin
         wrap_image = d + ls;
      end else begin
         wrap_image = d;
      end
   endfunction

   function automatic logic signed [AccW-1:0] sat_add(
      input logic signed [AccW-1:0] a,
      input logic signed [AccW-1:0] b);
      logic signed [AccW:0] s;
      s = {a[AccW-1], a} + {b[AccW-1], b};
      if (s[AccW] != s[AccW-1]) begin
         sat_add = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      end else begin
         sat_add = s[AccW-1:0];
      end
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff  <= '0;
         box_y_ff  <= '0;
         box_z_ff  <= '0;
         cutoff_ff <= ljpf_pkg::CUTOFF_SQ_RESET;
         cf6_ff    <= '0;
         cf12_ff   <= '0;
         ce6_ff    <= '0;
         ce12_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ljpf_pkg::CSR_BOX_X:    box_x_ff  <= csr_data[ljpf_pkg::POS_W-1:0];
            ljpf_pkg::CSR_BOX_Y:    box_y_ff  <= csr_data[ljpf_pkg::POS_W-1:0];
            ljpf_pkg::CSR_BOX_Z:    box_z_ff  <= csr_data[ljpf_pkg::POS_W-1:0];
            ljpf_pkg::CSR_CUTOFF:   cutoff_ff <= csr_data[ljpf_pkg::CUT_W-1:0];
            ljpf_pkg::CSR_FORCE6:   cf6_ff    <= csr_data;
            ljpf_pkg::CSR_FORCE12:  cf12_ff   <= csr_data;
            ljpf_pkg::CSR_ENERGY6:  ce6_ff    <= csr_data;
            ljpf_pkg::CSR_ENERGY12: ce12_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Distance pipeline: wrapped differences, squares, sum.
   assign sq_x = d_x_ff * d_x_ff;
   assign sq_y = d_y_ff * d_y_ff;
   assign sq_z = d_z_ff * d_z_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == ljpf_pkg::DP_LOAD) begin
         req_ff <= req_data;
      end
      if (cmd.op == ljpf_pkg::DP_DIFF) begin
         d_x_ff <= wrap_image(req_ff.pos_i_x, req_ff.pos_j_x, box_x_ff);
         d_y_ff <= wrap_image(req_ff.pos_i_y, req_ff.pos_j_y, box_y_ff);
         d_z_ff <= wrap_image(req_ff.pos_i_z, req_ff.pos_j_z, box_z_ff);
      end
      if (cmd.op == ljpf_pkg::DP_SQR) begin
         sq_x_ff <= sq_x;
         sq_y_ff <= sq_y;
         sq_z_ff <= sq_z;
      end
      if (cmd.op == ljpf_pkg::DP_SUM) begin
         r2_ff <= sq_x_ff + sq_y_ff + sq_z_ff;
      end
      mag_x_ff <= d_x_ff[ljpf_pkg::DIFF_W-1] ? MAG_W'(-d_x_ff) : MAG_W'(d_x_ff);
      mag_y_ff <= d_y_ff[ljpf_pkg::DIFF_W-1] ? MAG_W'(-d_y_ff) : MAG_W'(d_y_ff);
      mag_z_ff <= d_z_ff[ljpf_pkg::DIFF_W-1] ? MAG_W'(-d_z_ff) : MAG_W'(d_z_ff);
      mag_f_ff <= f_ff[AccW-1] ? AccW'(-f_ff) : AccW'(f_ff);
   end

   assign in_range_i = (32'(req_ff.index_i) < ljpf_pkg::ATOM_COUNT);
   assign in_range_j = (32'(req_ff.index_j) < ljpf_pkg::ATOM_COUNT);

   // Restoring divider: all-ones dividend over r2, one quotient bit a cycle.
   assign trial    = {rem_ff, 1'b1};
   assign trial_ge = (trial >= {1'b0, r2_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.op == ljpf_pkg::DP_DIV_START) begin
         div_cnt_ff <= '0;
      end else if (cmd.op == ljpf_pkg::DP_DIV_STEP) begin
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ljpf_pkg::DP_DIV_START) begin
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (cmd.op == ljpf_pkg::DP_DIV_STEP) begin
         rem_ff <= trial_ge ? ljpf_pkg::R2_W'(trial - {1'b0, r2_ff})
                            : ljpf_pkg::R2_W'(trial);
         q_ff   <= {q_ff[62:0], trial_ge};
      end
   end

   // Operand selection for the product sequence.
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mul_sh16  = 1'b0;
      mul_cap47 = 1'b0;
      unique case (cmd.mul_idx)
         ljpf_pkg::MUL_INV4: begin
            mul_a = q_ff;
            mul_b = q_ff;
         end
         ljpf_pkg::MUL_INV6: begin
            mul_a = q_ff;
            mul_b = inv4_ff;
         end
         ljpf_pkg::MUL_INV8: begin
            mul_a = inv4_ff;
            mul_b = inv4_ff;
         end
         ljpf_pkg::MUL_INV12: begin
            mul_a = inv4_ff;
            mul_b = inv8_ff;
         end
         ljpf_pkg::MUL_INV14: begin
            mul_a = inv6_ff;
            mul_b = inv8_ff;
         end
         ljpf_pkg::MUL_TF6: begin
            mul_a     = 64'(cf6_ff);
            mul_b     = inv8_ff;
            mul_cap47 = 1'b1;
         end
         ljpf_pkg::MUL_F: begin
            mul_a     = 64'(cf12_ff);
            mul_b     = inv14_ff;
            mul_cap47 = 1'b1;
         end
         ljpf_pkg::MUL_TE12: begin
            mul_a     = 64'(ce12_ff);
            mul_b     = inv12_ff;
            mul_cap47 = 1'b1;
         end
         ljpf_pkg::MUL_E: begin
            mul_a     = 64'(ce6_ff);
            mul_b     = inv6_ff;
            mul_cap47 = 1'b1;
         end
         ljpf_pkg::MUL_COMP_X: begin
            mul_a     = 64'(mag_f_ff);
            mul_b     = 64'(mag_x_ff);
            mul_sh16  = 1'b1;
            mul_cap47 = 1'b1;
         end
         ljpf_pkg::MUL_COMP_Y: begin
            mul_a     = 64'(mag_f_ff);
            mul_b     = 64'(mag_y_ff);
            mul_sh16  = 1'b1;
            mul_cap47 = 1'b1;
         end
         ljpf_pkg::MUL_COMP_Z: begin
            mul_a     = 64'(mag_f_ff);
            mul_b     = 64'(mag_z_ff);
            mul_sh16  = 1'b1;
            mul_cap47 = 1'b1;
         end
         default: ;
      endcase
   end

   assign mul_start = (cmd.op == ljpf_pkg::DP_MUL_START);

   ljpf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .sh16   (mul_sh16),
      .cap47  (mul_cap47),
      .done   (mul_done),
      .result (mul_res)
   );

   assign res48 = mul_res[AccW-1:0];

   // The component sign follows the product of the force and difference signs.
   always_comb begin
      unique case (mul_dest_ff)
         ljpf_pkg::MUL_COMP_X: comp_neg = f_ff[AccW-1] ^ d_x_ff[ljpf_pkg::DIFF_W-1];
         ljpf_pkg::MUL_COMP_Y: comp_neg = f_ff[AccW-1] ^ d_y_ff[ljpf_pkg::DIFF_W-1];
         default:              comp_neg = f_ff[AccW-1] ^ d_z_ff[ljpf_pkg::DIFF_W-1];
      endcase
   end

   // Results of the product sequence.
   always_ff @(posedge clock) begin
      if (mul_start) begin
         mul_dest_ff <= cmd.mul_idx;
      end
      if (mul_done) begin
         unique case (mul_dest_ff)
            ljpf_pkg::MUL_INV4:  inv4_ff  <= mul_res;
            ljpf_pkg::MUL_INV6:  inv6_ff  <= mul_res;
            ljpf_pkg::MUL_INV8:  inv8_ff  <= mul_res;
            ljpf_pkg::MUL_INV12: inv12_ff <= mul_res;
            ljpf_pkg::MUL_INV14: inv14_ff <= mul_res;
            ljpf_pkg::MUL_TF6:   tf6_ff   <= res48;
            ljpf_pkg::MUL_F:     f_ff     <= $signed(tf6_ff) - $signed(res48);
            ljpf_pkg::MUL_TE12:  te12_ff  <= res48;
            ljpf_pkg::MUL_E:     e_ff     <= $signed(te12_ff) - $signed(res48);
            ljpf_pkg::MUL_COMP_X: begin
               cx_ff  <= comp_neg ? -$signed(res48) : $signed(res48);
               ncx_ff <= comp_neg ? $signed(res48) : -$signed(res48);
            end
            ljpf_pkg::MUL_COMP_Y: begin
               cy_ff  <= comp_neg ? -$signed(res48) : $signed(res48);
               ncy_ff <= comp_neg ? $signed(res48) : -$signed(res48);
            end
            ljpf_pkg::MUL_COMP_Z: begin
               cz_ff  <= comp_neg ? -$signed(res48) : $signed(res48);
               ncz_ff <= comp_neg ? $signed(res48) : -$signed(res48);
            end
            default: ;
         endcase
      end
   end

   // Force memory, one row per atom holding {z, y, x}.
   assign addr_i = AW'(req_ff.index_i);
   assign addr_j = AW'(req_ff.index_j);

   assign add_x = (cmd.op == ljpf_pkg::DP_WR_J) ? ncx_ff : cx_ff;
   assign add_y = (cmd.op == ljpf_pkg::DP_WR_J) ? ncy_ff : cy_ff;
   assign add_z = (cmd.op == ljpf_pkg::DP_WR_J) ? ncz_ff : cz_ff;

   assign wr_en = (cmd.op == ljpf_pkg::DP_CLR) || (cmd.op == ljpf_pkg::DP_WR_I)
                  || (cmd.op == ljpf_pkg::DP_WR_J);
   assign rd_en = (cmd.op == ljpf_pkg::DP_RD_I) || (cmd.op == ljpf_pkg::DP_RD_J)
                  || (cmd.op == ljpf_pkg::DP_RD_A);

   always_comb begin
      priority if (cmd.op == ljpf_pkg::DP_CLR) begin
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.op == ljpf_pkg::DP_WR_J) begin
         wr_addr = addr_j;
         wr_data = {sat_add($signed(rd_data[3*AccW-1:2*AccW]), add_z),
                    sat_add($signed(rd_data[2*AccW-1:AccW]), add_y),
                    sat_add($signed(rd_data[AccW-1:0]), add_x)};
      end else begin
         wr_addr = addr_i;
         wr_data = {sat_add($signed(rd_data[3*AccW-1:2*AccW]), add_z),
                    sat_add($signed(rd_data[2*AccW-1:AccW]), add_y),
                    sat_add($signed(rd_data[AccW-1:0]), add_x)};
      end
   end

   assign rd_addr = (cmd.op == ljpf_pkg::DP_RD_J) ? addr_j : addr_i;

   ljpf_ram #(
      .WIDTH (3 * AccW),
      .DEPTH (ljpf_pkg::ATOM_COUNT)
   ) u_force_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Clearing pass counter and energy total.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         energy_ff  <= '0;
      end else if (cmd.op == ljpf_pkg::DP_CLR) begin
         clr_cnt_ff <= (clr_cnt_ff == CLR_LAST) ? '0 : clr_cnt_ff + AW'(1);
         energy_ff  <= '0;
      end else if (cmd.op == ljpf_pkg::DP_WR_I) begin
         energy_ff <= sat_add(energy_ff, e_ff);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.op == ljpf_pkg::DP_RSP_LOAD) begin
         rsp_ff.atom_index   <= req_ff.index_i;
         rsp_ff.force_x      <= in_range_i ? rd_data[AccW-1:0] : '0;
         rsp_ff.force_y      <= in_range_i ? rd_data[2*AccW-1:AccW] : '0;
         rsp_ff.force_z      <= in_range_i ? rd_data[3*AccW-1:2*AccW] : '0;
         rsp_ff.energy_total <= energy_ff;
      end
   end

   assign rsp_data = rsp_ff;

   assign status.pair_ok  = (req_ff.index_i < req_ff.index_j) && in_range_i && in_range_j
                            && (r2_ff != '0)
                            && (r2_ff <= {4'b0000, cutoff_ff, 16'h0000});
   assign status.clr_last = (clr_cnt_ff == CLR_LAST);
   assign status.div_last = (div_cnt_ff == DIV_LAST);
   assign status.mul_done = mul_done;

endmodule

>>> hw/rtl/ljpf_ctrl.sv
// Controller state machine: sequences clear, pair and read operations and
// owns the request and result handshakes. Depends on ljpf_pkg.
module ljpf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [1:0]           req_func,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ljpf_pkg::cmd_type    cmd,
   input  ljpf_pkg::status_type status
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DIFF   = 4'd2;
   localparam logic [3:0] ST_SQR    = 4'd3;
   localparam logic [3:0] ST_SUM    = 4'd4;
   localparam logic [3:0] ST_CHECK  = 4'd5;
   localparam logic [3:0] ST_DIV_GO = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_MUL_GO = 4'd8;
   localparam logic [3:0] ST_MUL    = 4'd9;
   localparam logic [3:0] ST_RD_I   = 4'd10;
   localparam logic [3:0] ST_WR_I   = 4'd11;
   localparam logic [3:0] ST_RD_J   = 4'd12;
   localparam logic [3:0] ST_WR_J   = 4'd13;
   localparam logic [3:0] ST_RD_A   = 4'd14;
   localparam logic [3:0] ST_RSP    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [3:0] mul_idx_ff, mul_idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;
   logic       rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_RSP) && rsp_free;

   // Next state and datapath command.
   always_comb begin
      state_in    = state_ff;
      mul_idx_in  = mul_idx_ff;
      cmd.op      = ljpf_pkg::DP_NOP;
      cmd.mul_idx = mul_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = ljpf_pkg::DP_CLR;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op = ljpf_pkg::DP_LOAD;
               unique case (req_func)
                  ljpf_pkg::FUNC_CLEAR: state_in = ST_CLEAR;
                  ljpf_pkg::FUNC_PAIR:  state_in = ST_DIFF;
                  ljpf_pkg::FUNC_READ:  state_in = ST_RD_A;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIFF: begin
            cmd.op   = ljpf_pkg::DP_DIFF;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            cmd.op   = ljpf_pkg::DP_SQR;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = ljpf_pkg::DP_SUM;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.pair_ok ? ST_DIV_GO : ST_IDLE;
         end
         ST_DIV_GO: begin
            cmd.op   = ljpf_pkg::DP_DIV_START;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = ljpf_pkg::DP_DIV_STEP;
            if (status.div_last) begin
               mul_idx_in = ljpf_pkg::MUL_INV4;
               state_in   = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            cmd.op   = ljpf_pkg::DP_MUL_START;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (status.mul_done) begin
               if (mul_idx_ff == ljpf_pkg::MUL_COMP_Z) begin
                  state_in = ST_RD_I;
               end else begin
                  mul_idx_in = mul_idx_ff + 4'd1;
                  state_in   = ST_MUL_GO;
               end
            end
         end
         ST_RD_I: begin
            cmd.op   = ljpf_pkg::DP_RD_I;
            state_in = ST_WR_I;
         end
         ST_WR_I: begin
            cmd.op   = ljpf_pkg::DP_WR_I;
            state_in = ST_RD_J;
         end
         ST_RD_J: begin
            cmd.op   = ljpf_pkg::DP_RD_J;
            state_in = ST_WR_J;
         end
         ST_WR_J: begin
            cmd.op   = ljpf_pkg::DP_WR_J;
            state_in = ST_IDLE;
         end
         ST_RD_A: begin
            cmd.op   = ljpf_pkg::DP_RD_A;
            state_in = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_free) begin
               cmd.op   = ljpf_pkg::DP_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The result beat stays up until taken, and a new one may replace it then.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mul_idx_ff   <= ljpf_pkg::MUL_INV4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_idx_ff   <= mul_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside the product wait state");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == ljpf_pkg::DP_RSP_LOAD) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded over an untaken beat");

   a_mul_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_GO) |-> (mul_idx_ff <= ljpf_pkg::MUL_COMP_Z))
      else $error("product index past the last component");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && !status.clr_last |=> (state_ff == ST_CLEAR))
      else $error("clearing pass left early");
`endif

endmodule
